@@ hdl/bdhr_pkg.sv @@
package bdhr_pkg;

    localparam int NumButtonsDef = 6;
    localparam int PinW          = 6;
    localparam int TimeW         = 32;
    localparam int CfgDataW      = 16;
    localparam int CfgIdxW       = 2;
    localparam int EvIdxW        = 3;
    localparam int EvCodeW       = 2;
    localparam int MaxResults    = 12;
    localparam int EvCntW        = 4;
    // Output queue: at most three entries are written per cycle.
    localparam int FifoDepth     = 16;
    localparam int FifoAw        = $clog2(FifoDepth);
    localparam int MaxPush       = 3;

    localparam logic [CfgDataW-1:0] DebounceRst = CfgDataW'(50);
    localparam logic [CfgDataW-1:0] HoldRst     = CfgDataW'(1000);
    localparam logic [CfgDataW-1:0] RepeatRst   = CfgDataW'(200);

    typedef enum logic [EvCodeW-1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_HOLD     = 2'd2,
        EV_REPEAT   = 2'd3
    } t_ev_code;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_HOLD     = 2'd1,
        CFG_REPEAT   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             stable_pressed;
        logic             last_raw_pressed;
        logic [TimeW-1:0] change_time;
        logic [TimeW-1:0] press_start_time;
        logic [TimeW-1:0] repeat_time;
        logic             hold_sent;
    } t_btn_state;

    typedef struct packed {
        logic [EvIdxW-1:0] button_index;
        t_ev_code          event_code;
        logic              last_event;
    } t_event;

endpackage

@@ hdl/bdhr_ram.sv @@
module bdhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/button_debounce_hold_repeat_top.sv @@
// Button debouncer with hold detection and auto-repeat.
// Input channel (i_in_valid / o_in_ready): one transaction is one scan, a
// millisecond timestamp and the active-low pin levels of the buttons.
// Output channel (o_out_valid / i_out_ready): one transaction is one event,
// the button, the event code and a flag set on the final event of a scan.
// Configuration is a plain write port (debounce, hold and repeat times) that
// must only be used while the block is idle.
// Per-button state lives in one RAM with a registered read. A scan is walked
// one button per cycle while the queue has room: read the entry, update it
// in the next cycle and write it back, forwarding the written word when the
// same entry is read at once. The next scan is accepted in the cycle the last
// button of the current one is read. Events leave one per cycle while the
// receiver is ready. Each event is held back until the next one of the
// same scan, or the end of the scan, is known, so that the final event can
// be flagged.
// A stalled receiver fills a 16-entry event queue; the walk pauses when the
// queue cannot take another six events, and then so does the input channel.
// Reset restores the default times and marks all RAM entries as cleared;
// no clearing pass is needed, the block is ready right after reset.
module button_debounce_hold_repeat_top #(
    parameter int NUM_BUTTONS = bdhr_pkg::NumButtonsDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [bdhr_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [bdhr_pkg::CfgDataW-1:0]    i_cfg_data,
    // Scan input.
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bdhr_pkg::TimeW-1:0]       i_now_ms,
    input  logic [bdhr_pkg::PinW-1:0]        i_pin_levels,
    // Event output.
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bdhr_pkg::EvIdxW-1:0]      o_button_index,
    output logic [bdhr_pkg::EvCodeW-1:0]     o_event_code,
    output logic                             o_last_event
);

    import bdhr_pkg::*;

    localparam int IdxW     = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int StW      = $bits(t_btn_state);
    // Room for the events of the button in the update stage and of the one
    // being read now.
    localparam int IssueMax = FifoDepth - 2 * MaxPush;

    // Configuration registers.
    logic [CfgDataW-1:0] r_debounce_ms;
    logic [CfgDataW-1:0] r_hold_ms;
    logic [CfgDataW-1:0] r_repeat_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DebounceRst;
            r_hold_ms     <= HoldRst;
            r_repeat_ms   <= RepeatRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_HOLD:     r_hold_ms     <= i_cfg_data;
                CFG_REPEAT:   r_repeat_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pressed level per button; buttons without a pin read as released.
    logic [NUM_BUTTONS-1:0] w_raw_vec;

    for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_raw
        if (gi < PinW) begin : g_pin
            assign w_raw_vec[gi] = ~i_pin_levels[gi];
        end else begin : g_nopin
            assign w_raw_vec[gi] = 1'b0;
        end
    end

    // Walk stage: holds the current scan and reads one entry per cycle while the queue has room.
    logic                   r_busy;
    logic [TimeW-1:0]       r_now;
    logic [NUM_BUTTONS-1:0] r_raw_vec;
    logic [IdxW-1:0]        r_idx;
    logic [FifoAw:0]        r_cnt;
    logic                   w_issue;
    logic                   w_walk_end;
    logic                   w_in_acc;

    assign w_issue    = r_busy && (r_cnt <= (FifoAw+1)'(IssueMax));
    assign w_walk_end = w_issue && (r_idx == IdxW'(NUM_BUTTONS - 1));
    assign o_in_ready = !r_busy || w_walk_end;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_walk_end) begin
            r_busy <= 1'b0;
        end else if (w_issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now     <= i_now_ms;
            r_raw_vec <= w_raw_vec;
        end
    end

    // Update stage registers.
    logic             r_b_vld;
    logic             r_b_last;
    logic [IdxW-1:0]  r_b_idx;
    logic [TimeW-1:0] r_b_now;
    logic             r_b_raw;
    logic             r_b_init;
    logic             r_b_fwd;
    t_btn_state       r_fwd_data;
    logic [StW-1:0]   w_ram_q;
    t_btn_state       w_nx;
    logic             w_fwd;
    logic [NUM_BUTTONS-1:0] r_ent_vld;

    // The entry read now is the one being written back this cycle.
    assign w_fwd = r_b_vld && (r_b_idx == r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            r_b_vld <= w_issue;
            if (r_b_vld) begin
                r_ent_vld[r_b_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b_last   <= w_walk_end;
            r_b_idx    <= r_idx;
            r_b_now    <= r_now;
            r_b_raw    <= r_raw_vec[r_idx];
            r_b_init   <= r_ent_vld[r_idx];
            r_b_fwd    <= w_fwd;
            r_fwd_data <= w_nx;
        end
    end

    bdhr_ram #(
        .WIDTH (StW),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_vld),
        .i_waddr (r_b_idx),
        .i_wdata (w_nx),
        .i_re    (w_issue),
        .i_raddr (r_idx),
        .o_rdata (w_ram_q)
    );

    // Per-button update and event generation.
    t_btn_state       w_cur;
    logic             w_e1_v;
    logic             w_e2_v;
    t_ev_code         w_e1_code;
    t_ev_code         w_e2_code;
    logic             w_c1;
    logic             w_c2;
    logic [EvCntW-1:0] r_ev_cnt;

    always_comb begin
        logic             changed;
        logic             deb_ok;
        logic             accept;
        logic             press;
        logic             hold_ok;
        logic             rep_ok;
        logic [TimeW-1:0] d_ct;
        logic [TimeW-1:0] d_pst;
        logic [TimeW-1:0] d_rt;

        if (r_b_fwd) begin
            w_cur = r_fwd_data;
        end else if (r_b_init) begin
            w_cur = t_btn_state'(w_ram_q);
        end else begin
            w_cur = '0;
        end
        w_nx      = w_cur;
        w_e1_v    = 1'b0;
        w_e2_v    = 1'b0;
        w_e1_code = r_b_raw ? EV_PRESSED : EV_RELEASED;
        w_e2_code = EV_HOLD;

        // Differences are taken against the stored times; a time that is
        // replaced by now in this update gives a difference of zero.
        d_ct  = r_b_now - w_cur.change_time;
        d_pst = r_b_now - w_cur.press_start_time;
        d_rt  = r_b_now - w_cur.repeat_time;

        changed = (r_b_raw != w_cur.last_raw_pressed);
        if (changed) begin
            w_nx.last_raw_pressed = r_b_raw;
            w_nx.change_time      = r_b_now;
            deb_ok                = (r_debounce_ms == '0);
        end else begin
            deb_ok = (d_ct >= TimeW'(r_debounce_ms));
        end

        accept = deb_ok && (r_b_raw != w_cur.stable_pressed);
        press  = accept && r_b_raw;
        if (accept) begin
            w_nx.stable_pressed = r_b_raw;
            w_e1_v              = 1'b1;
        end
        if (press) begin
            w_nx.press_start_time = r_b_now;
            w_nx.hold_sent        = 1'b0;
            hold_ok               = (r_hold_ms == '0);
        end else begin
            hold_ok = (d_pst >= TimeW'(r_hold_ms));
        end
        rep_ok = (d_rt >= TimeW'(r_repeat_ms));

        if (w_nx.stable_pressed) begin
            if (!w_nx.hold_sent && hold_ok) begin
                w_nx.hold_sent   = 1'b1;
                w_nx.repeat_time = r_b_now;
                w_e2_v           = 1'b1;
                w_e2_code        = EV_HOLD;
            end else if (w_nx.hold_sent && rep_ok) begin
                w_nx.repeat_time = r_b_now;
                w_e2_v           = 1'b1;
                w_e2_code        = EV_REPEAT;
            end
        end
    end

    // Events past the per-scan limit are dropped; the state still updates.
    assign w_c1 = r_b_vld && w_e1_v && (r_ev_cnt < EvCntW'(MaxResults));
    assign w_c2 = r_b_vld && w_e2_v &&
                  ((r_ev_cnt + EvCntW'(w_c1)) < EvCntW'(MaxResults));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_cnt <= '0;
        end else if (r_b_vld) begin
            if (r_b_last) begin
                r_ev_cnt <= '0;
            end else begin
                r_ev_cnt <= r_ev_cnt + EvCntW'(w_c1) + EvCntW'(w_c2);
            end
        end
    end

    // The newest event of a scan waits in a pending register until it is
    // known whether it is the final one. Each cycle the pending event and
    // the new ones are packed in order; all but the newest go to the queue,
    // or all of them, flagged at the end, on the last button of the scan.
    logic   r_pend_vld;
    t_event r_pend;
    t_event w_e1;
    t_event w_e2;
    t_event w_item [MaxPush];
    logic [1:0] w_total;
    logic [1:0] w_push_n;
    logic       w_pend_load;
    logic       w_pend_clr;
    t_event     w_pend_nx;

    assign w_e1 = '{button_index: EvIdxW'(r_b_idx), event_code: w_e1_code, last_event: 1'b0};
    assign w_e2 = '{button_index: EvIdxW'(r_b_idx), event_code: w_e2_code, last_event: 1'b0};

    always_comb begin
        w_total     = 2'(r_pend_vld) + 2'(w_c1) + 2'(w_c2);
        w_item[0]   = r_pend_vld ? r_pend : (w_c1 ? w_e1 : w_e2);
        w_item[1]   = r_pend_vld ? (w_c1 ? w_e1 : w_e2) : w_e2;
        w_item[2]   = w_e2;
        w_push_n    = '0;
        w_pend_load = 1'b0;
        w_pend_clr  = 1'b0;
        w_pend_nx   = w_item[0];
        if (r_b_vld) begin
            if (r_b_last) begin
                w_push_n   = w_total;
                w_pend_clr = 1'b1;
                if (w_total != '0) begin
                    w_item[w_total - 2'd1].last_event = 1'b1;
                end
            end else if (w_c1 || w_c2) begin
                w_push_n    = w_total - 2'd1;
                w_pend_load = 1'b1;
                w_pend_nx   = w_item[w_total - 2'd1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (w_pend_clr) begin
            r_pend_vld <= 1'b0;
        end else if (w_pend_load) begin
            r_pend_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pend_load) begin
            r_pend <= w_pend_nx;
        end
    end

    // Event queue.
    t_event            r_fifo [FifoDepth];
    logic [FifoAw-1:0] r_wp;
    logic [FifoAw-1:0] r_rp;
    logic              w_pop;

    assign o_out_valid    = (r_cnt != '0);
    assign w_pop          = o_out_valid && i_out_ready;
    assign o_button_index = r_fifo[r_rp].button_index;
    assign o_event_code   = r_fifo[r_rp].event_code;
    assign o_last_event   = r_fifo[r_rp].last_event;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MaxPush; k++) begin
            if (2'(k) < w_push_n) begin
                r_fifo[r_wp + FifoAw'(k)] <= w_item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FifoAw'(w_push_n);
            r_rp  <= r_rp + FifoAw'(w_pop);
            r_cnt <= r_cnt + (FifoAw+1)'(w_push_n) - (FifoAw+1)'(w_pop);
        end
    end

    // The queue never holds more than its depth.
    a_fifo_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FifoAw+1)'(FifoDepth))
        else $error("event queue overflow");

    // A pending event always belongs to a scan that is still being walked.
    a_pend_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_busy || r_b_vld))
        else $error("pending event outside of a scan");

    // The per-scan event count stays within the limit.
    a_ev_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_cnt <= EvCntW'(MaxResults))
        else $error("per-scan event count exceeds the limit");

    // Finishing a scan always leaves no pending event behind.
    a_scan_flush : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_last) |=> !r_pend_vld)
        else $error("pending event survives the end of a scan");

endmodule
